// ===== rtl/wbpt_pkg.sv =====
package wbpt_pkg;

    // Operation codes carried by an input request.
    localparam logic [2:0] OP_TICK   = 3'd0;
    localparam logic [2:0] OP_START  = 3'd1;
    localparam logic [2:0] OP_PAUSE  = 3'd2;
    localparam logic [2:0] OP_RESET  = 3'd3;
    localparam logic [2:0] OP_SELECT = 3'd4;
    localparam logic [2:0] OP_CLEAR  = 3'd5;

    // Phase codes.
    localparam logic [1:0] PH_WORK  = 2'd0;
    localparam logic [1:0] PH_SHORT = 2'd1;
    localparam logic [1:0] PH_LONG  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_MIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_EVERY  = 3'd4;

    // Task table geometry.
    localparam int TASK_SLOTS = 64;
    localparam int TASK_IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

    // Field widths.
    localparam int OP_W    = 3;
    localparam int TID_W   = 6;
    localparam int SEC_W   = 32;
    localparam int CNT_W   = 16;
    localparam int MIN_W   = 8;
    localparam int EVERY_W = 4;
    localparam int REM_W   = 14;

    localparam int SECS_PER_MIN = 60;
    localparam int REM_MAX      = ((1 << MIN_W) - 1) * SECS_PER_MIN;

    localparam logic [EVERY_W-1:0] CYCLES_MAX = '1;

    localparam logic [MIN_W-1:0]   RST_WORK_MIN  = 8'd25;
    localparam logic [MIN_W-1:0]   RST_SHORT_MIN = 8'd5;
    localparam logic [MIN_W-1:0]   RST_LONG_MIN  = 8'd15;
    localparam logic [EVERY_W-1:0] RST_EVERY     = 4'd4;

    typedef logic [SEC_W-1:0] sec_t;

    function automatic logic [REM_W-1:0] min_to_secs(input logic [MIN_W-1:0] m);
        logic [REM_W-1:0] r;
        r = REM_W'(m) * REM_W'(SECS_PER_MIN);
        return r;
    endfunction

    function automatic sec_t sat_inc32(input sec_t v);
        sec_t r;
        r = (v == '1) ? v : v + SEC_W'(1);
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc16(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == '1) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

// ===== rtl/wbpt_in_if.sv =====
interface wbpt_in_if;
    logic                        valid;
    logic                        ready;
    logic [wbpt_pkg::OP_W-1:0]   operation;
    logic [wbpt_pkg::TID_W-1:0]  task_id;

    modport source (output valid, output operation, output task_id, input ready);
    modport sink   (input valid, input operation, input task_id, output ready);
endinterface

// ===== rtl/wbpt_out_if.sv =====
interface wbpt_out_if;
    logic                        valid;
    logic                        ready;
    wbpt_pkg::sec_t              shown_seconds;
    logic [1:0]                  phase;
    logic                        running;
    logic                        phase_changed;
    logic                        work_phase_done;
    logic                        session_valid;
    wbpt_pkg::sec_t              session_seconds;
    wbpt_pkg::sec_t              today_seconds;
    wbpt_pkg::sec_t              total_seconds;
    logic [wbpt_pkg::CNT_W-1:0]  done_count;
    logic                        task_active;
    wbpt_pkg::sec_t              task_seconds;

    modport source (
        output valid, output shown_seconds, output phase, output running,
        output phase_changed, output work_phase_done, output session_valid,
        output session_seconds, output today_seconds, output total_seconds,
        output done_count, output task_active, output task_seconds,
        input ready
    );
    modport sink (
        input valid, input shown_seconds, input phase, input running,
        input phase_changed, input work_phase_done, input session_valid,
        input session_seconds, input today_seconds, input total_seconds,
        input done_count, input task_active, input task_seconds,
        output ready
    );
endinterface

// ===== rtl/wbpt_ram.sv =====
module wbpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read-first: a read at the address being written returns the old word.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/work_break_phase_timer.sv =====
// Channel | Dir | Payload                                           | Handshake
// evt     | in  | operation, task_id                                | valid/ready
// res     | out | shown_seconds .. task_seconds (one per request)   | valid/ready
// cfg     | in  | cfg_index, cfg_data                               | cfg_write
//
// One request is accepted every cycle while results are taken; each result
// passes from its request through the execute register to the result register.
// The task table lives in a RAM with a registered read, so the entry of the
// current task is read when the request is accepted and used in the execute register.
// Reset clears all control state and the per-entry valid bits of the task
// table at once; there is no clearing pass, an entry never written reads zero.
// A stalled result holds the result register; one more request can still
// enter the execute register, after which the input side waits.

module work_break_phase_timer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [wbpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wbpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    wbpt_in_if.sink                           evt,
    wbpt_out_if.source                        res
);

    // ------------------------------------------------------------------
    // Configuration registers. The lengths and spacing are only read when a phase is loaded.
    // ------------------------------------------------------------------
    logic                                count_mode_reg;
    logic [wbpt_pkg::MIN_W-1:0]          work_min_reg;
    logic [wbpt_pkg::MIN_W-1:0]          short_min_reg;
    logic [wbpt_pkg::MIN_W-1:0]          long_min_reg;
    logic [wbpt_pkg::EVERY_W-1:0]        long_every_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_mode_reg <= 1'b0;
            work_min_reg   <= wbpt_pkg::RST_WORK_MIN;
            short_min_reg  <= wbpt_pkg::RST_SHORT_MIN;
            long_min_reg   <= wbpt_pkg::RST_LONG_MIN;
            long_every_reg <= wbpt_pkg::RST_EVERY;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                wbpt_pkg::CFG_COUNT_MODE: count_mode_reg <= cfg_data[0];
                wbpt_pkg::CFG_WORK_MIN:   work_min_reg   <= cfg_data;
                wbpt_pkg::CFG_SHORT_MIN:  short_min_reg  <= cfg_data;
                wbpt_pkg::CFG_LONG_MIN:   long_min_reg   <= cfg_data;
                wbpt_pkg::CFG_LONG_EVERY: long_every_reg <= cfg_data[wbpt_pkg::EVERY_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and pipeline control.
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic res_valid_reg;
    logic s1_adv;
    logic fire;
    logic acc;

    assign s1_adv    = !res_valid_reg || res.ready;
    assign fire      = s1_valid_reg && s1_adv;
    assign evt.ready = !s1_valid_reg || s1_adv;
    assign acc       = evt.valid && evt.ready;
    assign res.valid = res_valid_reg;

    // ------------------------------------------------------------------
    // Front end: the task selection depends on nothing but the request, so
    // it is resolved at acceptance and the table entry is read right away.
    // ------------------------------------------------------------------
    logic                              task_valid_reg;
    logic [wbpt_pkg::TASK_IDX_W-1:0]   task_index_reg;
    logic                              task_valid_next;
    logic [wbpt_pkg::TASK_IDX_W-1:0]   task_index_next;

    always_comb
    begin
        task_valid_next = task_valid_reg;
        task_index_next = task_index_reg;
        case (evt.operation)
            wbpt_pkg::OP_SELECT:
            begin
                if (32'(evt.task_id) < wbpt_pkg::TASK_SLOTS)
                begin
                    task_valid_next = 1'b1;
                    task_index_next = wbpt_pkg::TASK_IDX_W'(evt.task_id);
                end
            end
            wbpt_pkg::OP_CLEAR: task_valid_next = 1'b0;
            default: ;
        endcase
    end

    // Task table RAM and the valid bit of each entry.
    logic                              ram_we;
    logic [wbpt_pkg::TASK_IDX_W-1:0]   ram_waddr;
    wbpt_pkg::sec_t                    ram_wdata;
    wbpt_pkg::sec_t                    ram_rdata;
    logic [wbpt_pkg::TASK_SLOTS-1:0]   entry_ok_reg;

    wbpt_ram #(
        .WIDTH (wbpt_pkg::SEC_W),
        .DEPTH (wbpt_pkg::TASK_SLOTS)
    ) u_task_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (acc),
        .raddr (task_index_next),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_ok_reg <= '0;
        end
        else if (ram_we)
        begin
            entry_ok_reg[ram_waddr] <= 1'b1;
        end
    end

    // Execute register. When the request ahead writes the very entry that is
    // read at acceptance, the RAM returns the old word, so the new word is
    // forwarded instead.
    logic [wbpt_pkg::OP_W-1:0]         s1_op_reg;
    logic                              s1_tvalid_reg;
    logic [wbpt_pkg::TASK_IDX_W-1:0]   s1_tidx_reg;
    logic                              s1_fwd_reg;
    wbpt_pkg::sec_t                    s1_fwd_data_reg;
    logic                              s1_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            task_valid_reg <= 1'b0;
            task_index_reg <= '0;
        end
        else
        begin
            if (acc)
            begin
                s1_valid_reg   <= 1'b1;
                task_valid_reg <= task_valid_next;
                task_index_reg <= task_index_next;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_op_reg       <= evt.operation;
            s1_tvalid_reg   <= task_valid_next;
            s1_tidx_reg     <= task_index_next;
            s1_fwd_reg      <= ram_we && (ram_waddr == task_index_next);
            s1_fwd_data_reg <= ram_wdata;
            s1_zero_reg     <= !entry_ok_reg[task_index_next];
        end
    end

    // ------------------------------------------------------------------
    // Timer state and the execute logic for one request.
    // ------------------------------------------------------------------
    logic [1:0]                        phase_reg,   phase_next;
    logic [wbpt_pkg::REM_W-1:0]        remain_reg,  remain_next;
    logic [wbpt_pkg::EVERY_W-1:0]      cycles_reg,  cycles_next;
    logic                              run_reg,     run_next;
    wbpt_pkg::sec_t                    elapsed_reg, elapsed_next;
    wbpt_pkg::sec_t                    start_reg,   start_next;
    wbpt_pkg::sec_t                    today_reg,   today_next;
    wbpt_pkg::sec_t                    total_reg,   total_next;
    logic [wbpt_pkg::CNT_W-1:0]        phases_reg,  phases_next;

    logic                              changed;
    logic                              done;
    logic                              sess_valid;
    wbpt_pkg::sec_t                    sess_secs;
    logic                              count_work;
    logic [wbpt_pkg::EVERY_W-1:0]      cycles_inc;
    wbpt_pkg::sec_t                    diff_a;
    wbpt_pkg::sec_t                    diff_b;
    wbpt_pkg::sec_t                    task_cur;
    wbpt_pkg::sec_t                    task_out;

    // Seconds worked in a session: the countdown runs from the start mark
    // down to what remains, the stopwatch from the start mark up.
    assign diff_a = count_mode_reg ? elapsed_reg : start_reg;
    assign diff_b = count_mode_reg ? start_reg : wbpt_pkg::SEC_W'(remain_reg);

    assign cycles_inc = (cycles_reg == wbpt_pkg::CYCLES_MAX) ? cycles_reg
                                                             : cycles_reg + 4'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        remain_next  = remain_reg;
        cycles_next  = cycles_reg;
        run_next     = run_reg;
        elapsed_next = elapsed_reg;
        start_next   = start_reg;
        phases_next  = phases_reg;
        changed      = 1'b0;
        done         = 1'b0;
        sess_valid   = 1'b0;
        sess_secs    = '0;
        count_work   = 1'b0;

        case (s1_op_reg)
            wbpt_pkg::OP_TICK:
            begin
                if (run_reg)
                begin
                    if (!count_mode_reg)
                    begin
                        if (remain_reg != '0)
                        begin
                            remain_next = remain_reg - 14'd1;
                            count_work  = (phase_reg == wbpt_pkg::PH_WORK);
                        end
                        else if (phase_reg == wbpt_pkg::PH_WORK)
                        begin
                            // A finished work phase leads into a break; every
                            // long_break_every-th one into the long break.
                            phases_next = wbpt_pkg::sat_inc16(phases_reg);
                            done        = 1'b1;
                            changed     = 1'b1;
                            if (cycles_inc >= long_every_reg)
                            begin
                                phase_next  = wbpt_pkg::PH_LONG;
                                remain_next = wbpt_pkg::min_to_secs(long_min_reg);
                                cycles_next = '0;
                            end
                            else
                            begin
                                phase_next  = wbpt_pkg::PH_SHORT;
                                remain_next = wbpt_pkg::min_to_secs(short_min_reg);
                                cycles_next = cycles_inc;
                            end
                        end
                        else
                        begin
                            phase_next  = wbpt_pkg::PH_WORK;
                            remain_next = wbpt_pkg::min_to_secs(work_min_reg);
                            changed     = 1'b1;
                        end
                    end
                    else
                    begin
                        elapsed_next = wbpt_pkg::sat_inc32(elapsed_reg);
                        count_work   = 1'b1;
                    end
                end
            end
            wbpt_pkg::OP_START:
            begin
                if (!run_reg)
                begin
                    run_next   = 1'b1;
                    start_next = count_mode_reg ? elapsed_reg
                                                : wbpt_pkg::SEC_W'(remain_reg);
                end
            end
            wbpt_pkg::OP_PAUSE:
            begin
                if (run_reg)
                begin
                    run_next = 1'b0;
                    if (count_mode_reg || (phase_reg == wbpt_pkg::PH_WORK))
                    begin
                        if (diff_a > diff_b)
                        begin
                            sess_valid = 1'b1;
                            sess_secs  = diff_a - diff_b;
                        end
                    end
                end
            end
            wbpt_pkg::OP_RESET:
            begin
                run_next = 1'b0;
                if (!count_mode_reg)
                begin
                    phase_next  = wbpt_pkg::PH_WORK;
                    remain_next = wbpt_pkg::min_to_secs(work_min_reg);
                    cycles_next = '0;
                    changed     = 1'b1;
                end
                else
                begin
                    elapsed_next = '0;
                end
            end
            default: ;
        endcase
    end

    assign today_next = count_work ? wbpt_pkg::sat_inc32(today_reg) : today_reg;
    assign total_next = count_work ? wbpt_pkg::sat_inc32(total_reg) : total_reg;

    // Current value of the selected task's entry, then its update.
    assign task_cur = s1_fwd_reg  ? s1_fwd_data_reg :
                      s1_zero_reg ? '0 : ram_rdata;

    assign ram_we    = fire && count_work && s1_tvalid_reg;
    assign ram_waddr = s1_tidx_reg;
    assign ram_wdata = wbpt_pkg::sat_inc32(task_cur);

    assign task_out = !s1_tvalid_reg ? '0 :
                      (count_work ? ram_wdata : task_cur);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= wbpt_pkg::PH_WORK;
            remain_reg  <= wbpt_pkg::min_to_secs(wbpt_pkg::RST_WORK_MIN);
            cycles_reg  <= '0;
            run_reg     <= 1'b0;
            elapsed_reg <= '0;
            start_reg   <= '0;
            today_reg   <= '0;
            total_reg   <= '0;
            phases_reg  <= '0;
        end
        else if (fire)
        begin
            phase_reg   <= phase_next;
            remain_reg  <= remain_next;
            cycles_reg  <= cycles_next;
            run_reg     <= run_next;
            elapsed_reg <= elapsed_next;
            start_reg   <= start_next;
            today_reg   <= today_next;
            total_reg   <= total_next;
            phases_reg  <= phases_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            res_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res.shown_seconds   <= count_mode_reg ? elapsed_next
                                                  : wbpt_pkg::SEC_W'(remain_next);
            res.phase           <= phase_next;
            res.running         <= run_next;
            res.phase_changed   <= changed;
            res.work_phase_done <= done;
            res.session_valid   <= sess_valid;
            res.session_seconds <= sess_secs;
            res.today_seconds   <= today_next;
            res.total_seconds   <= total_next;
            res.done_count      <= phases_next;
            res.task_active     <= s1_tvalid_reg;
            res.task_seconds    <= task_out;
        end
    end

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_remain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(remain_reg) <= wbpt_pkg::REM_MAX)
        else $error("remaining seconds beyond the longest phase");

    a_done_to_break: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res.work_phase_done |->
            res.phase_changed && (res.phase != wbpt_pkg::PH_WORK))
        else $error("completed work phase did not switch to a break");

    a_idle_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.task_active |-> res.task_seconds == '0)
        else $error("task seconds reported without an active task");

    a_entry_marked: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> entry_ok_reg[$past(ram_waddr)])
        else $error("written task entry not marked valid");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import wbpt_pkg::*;

    // Operation codes the block has no meaning for; it must report its state unchanged.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    // Register indexes in the order the settings plan lists their values.
    localparam logic [4:0][CFG_IDX_W-1:0] CFG_ORDER =
        {CFG_LONG_EVERY, CFG_LONG_MIN, CFG_SHORT_MIN, CFG_WORK_MIN, CFG_COUNT_MODE};

    localparam int SETTINGS_ROWS = 9;
    localparam int RANDOM_QUOTA  = 105;   // requests per random stretch
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int HOLD_AFTER    = 450;   // reports seen before the hold-off
    localparam int IDLE_LIMIT    = 2000;  // cycles without any handshake

    // One timer report, as carried by the result channel.
    typedef struct packed {
        sec_t                shown_seconds;
        logic [1:0]          phase;
        logic                running;
        logic                phase_changed;
        logic                work_phase_done;
        logic                session_valid;
        sec_t                session_seconds;
        sec_t                today_seconds;
        sec_t                total_seconds;
        logic [CNT_W-1:0]    done_count;
        logic                task_active;
        sec_t                task_seconds;
    } report_t;

    // The scoreboard keeps its own copy of the timer: settings, counters and the
    // per-task table. Every accepted request advances that copy and queues the
    // report the block has to produce for it.
    class timer_scoreboard;
        logic                stopwatch;
        logic [MIN_W-1:0]    work_min;
        logic [MIN_W-1:0]    short_min;
        logic [MIN_W-1:0]    long_min;
        logic [EVERY_W-1:0]  long_every;

        logic [1:0]          phase_now;
        logic [REM_W-1:0]    remaining;
        logic [EVERY_W-1:0]  cycles_done;
        logic                is_running;
        sec_t                elapsed;
        sec_t                session_start;
        sec_t                today;
        sec_t                total;
        logic [CNT_W-1:0]    phases_today;
        logic                task_valid;
        logic [TID_W-1:0]    task_slot;
        sec_t                task_secs [TASK_SLOTS];

        report_t             expected_reports [$];
        int                  mismatches;
        int                  checked;

        function new();
            stopwatch     = 1'b0;
            work_min      = RST_WORK_MIN;
            short_min     = RST_SHORT_MIN;
            long_min      = RST_LONG_MIN;
            long_every    = RST_EVERY;
            phase_now     = PH_WORK;
            remaining     = REM_W'(RST_WORK_MIN) * REM_W'(SECS_PER_MIN);
            cycles_done   = '0;
            is_running    = 1'b0;
            elapsed       = '0;
            session_start = '0;
            today         = '0;
            total         = '0;
            phases_today  = '0;
            task_valid    = 1'b0;
            task_slot     = '0;
            foreach (task_secs[i])
                task_secs[i] = '0;
            mismatches    = 0;
            checked       = 0;
        endfunction

        function sec_t bump(sec_t v);
            return (v == '1) ? v : v + 1;
        endfunction

        function logic [REM_W-1:0] phase_length(logic [MIN_W-1:0] m);
            return REM_W'(m) * REM_W'(SECS_PER_MIN);
        endfunction

        function void write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_COUNT_MODE: stopwatch  = data[0];
                CFG_WORK_MIN:   work_min   = data;
                CFG_SHORT_MIN:  short_min  = data;
                CFG_LONG_MIN:   long_min   = data;
                CFG_LONG_EVERY: long_every = data[EVERY_W-1:0];
                default: ;
            endcase
        endfunction

        function void count_work_second();
            today = bump(today);
            total = bump(total);
            if (task_valid)
                task_secs[task_slot] = bump(task_secs[task_slot]);
        endfunction

        function report_t advance_timer(logic [OP_W-1:0] op, logic [TID_W-1:0] tid);
            report_t r;
            longint  worked;
            r = '0;
            case (op)
                OP_TICK:
                    if (is_running)
                    begin
                        if (stopwatch)
                        begin
                            elapsed = bump(elapsed);
                            count_work_second();
                        end
                        else if (remaining != 0)
                        begin
                            remaining = remaining - 1'b1;
                            if (phase_now == PH_WORK)
                                count_work_second();
                        end
                        else if (phase_now == PH_WORK)
                        begin
                            if (cycles_done != CYCLES_MAX)
                                cycles_done = cycles_done + 1'b1;
                            if (phases_today != '1)
                                phases_today = phases_today + 1'b1;
                            r.work_phase_done = 1'b1;
                            if (cycles_done >= long_every)
                            begin
                                phase_now   = PH_LONG;
                                remaining   = phase_length(long_min);
                                cycles_done = '0;
                            end
                            else
                            begin
                                phase_now = PH_SHORT;
                                remaining = phase_length(short_min);
                            end
                            r.phase_changed = 1'b1;
                        end
                        else
                        begin
                            phase_now       = PH_WORK;
                            remaining       = phase_length(work_min);
                            r.phase_changed = 1'b1;
                        end
                    end
                OP_START:
                    if (!is_running)
                    begin
                        is_running    = 1'b1;
                        session_start = stopwatch ? elapsed : SEC_W'(remaining);
                    end
                OP_PAUSE:
                    if (is_running)
                    begin
                        is_running = 1'b0;
                        if (stopwatch || phase_now == PH_WORK)
                        begin
                            if (stopwatch)
                                worked = {32'd0, elapsed} - {32'd0, session_start};
                            else
                                worked = {32'd0, session_start} - {{50{1'b0}}, remaining};
                            if (worked > 0)
                            begin
                                r.session_valid   = 1'b1;
                                r.session_seconds = worked[SEC_W-1:0];
                            end
                        end
                    end
                OP_RESET:
                begin
                    is_running = 1'b0;
                    if (stopwatch)
                        elapsed = '0;
                    else
                    begin
                        phase_now       = PH_WORK;
                        remaining       = phase_length(work_min);
                        cycles_done     = '0;
                        r.phase_changed = 1'b1;
                    end
                end
                OP_SELECT:
                    if (int'(tid) < TASK_SLOTS)
                    begin
                        task_valid = 1'b1;
                        task_slot  = tid;
                    end
                OP_CLEAR:
                    task_valid = 1'b0;
                default: ;
            endcase
            r.shown_seconds = stopwatch ? elapsed : SEC_W'(remaining);
            r.phase         = phase_now;
            r.running       = is_running;
            r.today_seconds = today;
            r.total_seconds = total;
            r.done_count    = phases_today;
            r.task_active   = task_valid;
            r.task_seconds  = task_valid ? task_secs[task_slot] : '0;
            return r;
        endfunction

        function void note_event(logic [OP_W-1:0] op, logic [TID_W-1:0] tid);
            expected_reports.push_back(advance_timer(op, tid));
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            $display("%0t: %s", $time, msg);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                report_mismatch($sformatf("%s expected %0d, actual %0d", name, want, got));
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (expected_reports.size() == 0)
            begin
                report_mismatch($sformatf(
                    "report with no request outstanding: expected none, actual shown %0d",
                    got.shown_seconds));
                return;
            end
            want = expected_reports.pop_front();
            checked++;
            compare_field("shown_seconds",   want.shown_seconds,   got.shown_seconds);
            compare_field("phase",           want.phase,           got.phase);
            compare_field("running",         want.running,         got.running);
            compare_field("phase_changed",   want.phase_changed,   got.phase_changed);
            compare_field("work_phase_done", want.work_phase_done, got.work_phase_done);
            compare_field("session_valid",   want.session_valid,   got.session_valid);
            compare_field("session_seconds", want.session_seconds, got.session_seconds);
            compare_field("today_seconds",   want.today_seconds,   got.today_seconds);
            compare_field("total_seconds",   want.total_seconds,   got.total_seconds);
            compare_field("done_count",      want.done_count,      got.done_count);
            compare_field("task_active",     want.task_active,     got.task_active);
            compare_field("task_seconds",    want.task_seconds,    got.task_seconds);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    wbpt_in_if  evt_ch ();
    wbpt_out_if res_ch ();

    work_break_phase_timer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .evt       (evt_ch),
        .res       (res_ch)
    );

    timer_scoreboard sb;

    // Values per settings row: count_mode, work, short break, long break, long-break spacing.
    // Row 0 is the all-zero corner used by the directed part; the others feed the
    // random stretches, extremes of every register included.
    int settings_plan [SETTINGS_ROWS][5];

    int  requests_sent;   // requests with a defined operation
    int  rx_count;        // reports taken from the block
    int  idle_cycles;
    bit  no_gaps;         // set during stretches where neither side idles
    bit  hold_done;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Every report leaving the block is checked against the oldest expectation.
    always @(posedge clk)
    begin
        report_t observed;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            observed.shown_seconds   = res_ch.shown_seconds;
            observed.phase           = res_ch.phase;
            observed.running         = res_ch.running;
            observed.phase_changed   = res_ch.phase_changed;
            observed.work_phase_done = res_ch.work_phase_done;
            observed.session_valid   = res_ch.session_valid;
            observed.session_seconds = res_ch.session_seconds;
            observed.today_seconds   = res_ch.today_seconds;
            observed.total_seconds   = res_ch.total_seconds;
            observed.done_count      = res_ch.done_count;
            observed.task_active     = res_ch.task_active;
            observed.task_seconds    = res_ch.task_seconds;
            sb.check_report(observed);
            rx_count++;
        end
    end

    // The watchdog ends the run once no handshake of either channel has been
    // seen for a long time; the limit covers the longest intended hold-off
    // several times over.
    always @(posedge clk)
    begin
        if ((evt_ch.valid && evt_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles, giving up", $time, IDLE_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Result side: before each report the receiver stalls for a drawn number of
    // cycles, then keeps ready high until a report is taken. Ready only changes
    // at falling edges. Once, well into the random part, it holds off for a long
    // stretch so that the block's two internal stages fill and the request side
    // has to wait.
    initial
    begin
        int stall;
        res_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 15);
            if (!hold_done && rx_count >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                stall     = HOLD_CYCLES;
            end
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Offers one request: an optional gap with valid low, then valid high until
    // the block takes it. It is entered and left at a falling edge, and valid is
    // left high so that a back-to-back request never drops it for a step.
    task automatic offer_event(input logic [OP_W-1:0] op, input logic [TID_W-1:0] tid);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            evt_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        evt_ch.valid     <= 1'b1;
        evt_ch.operation <= op;
        evt_ch.task_id   <= tid;
        @(posedge clk);
        while (!evt_ch.ready)
            @(posedge clk);
        sb.note_event(op, tid);
        if (op <= OP_CLEAR)
            requests_sent++;
        @(negedge clk);
    endtask

    // Drops valid and waits until every report of the requests so far has come
    // back, so that the block is idle and registers may be written.
    task automatic drain_reports();
        evt_ch.valid <= 1'b0;
        while (sb.expected_reports.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    // Writes all five registers from one row of the plan on consecutive edges;
    // the write enable stays high across the burst and drops after it.
    task automatic apply_settings(input int row);
        logic [CFG_DATA_W-1:0] value;
        for (int i = 0; i < 5; i++)
        begin
            value      = CFG_DATA_W'(settings_plan[row][i]);
            cfg_write <= 1'b1;
            cfg_index <= CFG_ORDER[i];
            cfg_data  <= value;
            @(posedge clk);
            sb.write_setting(CFG_ORDER[i], value);
            @(negedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic offer_noise();
        offer_event(OP_W'($urandom_range(0, 7)), TID_W'($urandom));
    endtask

    // Random traffic shaped as work sessions: optionally pick a task, start,
    // run a batch of one-second ticks with the odd stray request mixed in, and
    // end with a pause or, less often, a reset. About one time in seven a
    // loose request of any kind goes in instead of a session.
    task automatic run_sessions(input int quota);
        int target;
        int ticks;
        target = requests_sent + quota;
        while (requests_sent < target)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                if ($urandom_range(0, 1) == 1)
                    offer_event(OP_SELECT, TID_W'($urandom));
                offer_event(OP_START, TID_W'($urandom));
                ticks = $urandom_range(1, 90);
                repeat (ticks)
                begin
                    if ($urandom_range(0, 99) < 4)
                        offer_noise();
                    else
                        offer_event(OP_TICK, TID_W'($urandom));
                end
                if ($urandom_range(0, 4) == 0)
                    offer_event(OP_RESET, TID_W'($urandom));
                else
                    offer_event(OP_PAUSE, TID_W'($urandom));
            end
            else
                offer_noise();
        end
    endtask

    initial
    begin
        sb = new();
        settings_plan = '{
            '{0,   0,   0,   0,  0},
            '{0,   1,   0,   1,  2},
            '{0,   0,   1,   0,  0},
            '{1, 255, 255, 255, 15},
            '{0,   2,   1,   1, 15},
            '{0, 255,   0, 255,  1},
            '{1,   0,   0,   0,  0},
            '{0,   1,   1,   0,  3},
            '{0,   1,   0,   2,  1}
        };
        requests_sent    = 0;
        rx_count         = 0;
        idle_cycles      = 0;
        no_gaps          = 1'b0;
        hold_done        = 1'b0;
        rst_n            = 1'b0;
        cfg_write        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        evt_ch.valid     = 1'b0;
        evt_ch.operation = OP_TICK;
        evt_ch.task_id   = '0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part under the reset settings (25 minute work phase).
        offer_event(OP_TICK,   6'd0);    // tick while stopped is ignored
        offer_event(OP_PAUSE,  6'd0);    // pause while stopped is ignored
        offer_event(OP_SELECT, 6'd63);   // highest task slot
        offer_event(OP_START,  6'd0);
        offer_event(OP_START,  6'd0);    // start while running is ignored
        repeat (3)
            offer_event(OP_TICK, 6'd0);
        offer_event(OP_PAUSE,  6'd0);    // reports a three second session
        offer_event(OP_TICK,   6'd0);
        offer_event(OP_SELECT, 6'd0);    // lowest task slot
        offer_event(OP_START,  6'd0);
        offer_event(OP_TICK,   6'd0);
        offer_event(OP_CLEAR,  6'd0);
        offer_event(OP_TICK,   6'd0);    // work second without a task
        offer_event(OP_SPARE_A, 6'd42);
        offer_event(OP_SPARE_B, 6'd21);
        offer_event(OP_RESET,  6'd0);
        drain_reports();

        // Zero-length phases with a long break after every work phase: each
        // tick at zero remaining switches phase, and a pause in the break
        // records no session. The new lengths only show once a reset reloads.
        apply_settings(0);
        offer_event(OP_TICK,   6'd0);
        offer_event(OP_RESET,  6'd0);
        offer_event(OP_START,  6'd0);
        offer_event(OP_TICK,   6'd0);    // work done, straight to long break
        offer_event(OP_PAUSE,  6'd0);
        offer_event(OP_START,  6'd0);
        offer_event(OP_TICK,   6'd0);    // long break over, back to work
        offer_event(OP_TICK,   6'd0);
        drain_reports();

        // Random stretches, one per settings row; every third one runs with
        // no idling on either side.
        for (int row = 1; row < SETTINGS_ROWS; row++)
        begin
            no_gaps = (row % 3 == 1);
            apply_settings(row);
            run_sessions(RANDOM_QUOTA);
            drain_reports();
        end
        no_gaps = 1'b0;
        repeat (4) @(posedge clk);

        $display("Sent %0d timer requests over %0d register settings; %0d reports checked.",
                 requests_sent, SETTINGS_ROWS + 1, sb.checked);
        $display("Covered countdown and stopwatch modes, phase changes, sessions and tasks.");
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
